[rtl/bles_pkg.sv]
// shared types, constants and helpers of the binary laplacian edge stream
package bles_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 2048;
  localparam int PosW      = 11;
  localparam int DimW      = 12;
  localparam int ColAw     = $clog2(MaxWidth);
  localparam int CfgIdxW   = 2;
  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);

  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = CfgIdxW'(1);

  localparam logic [DimW-1:0] WidthReset  = 12'd640;
  localparam logic [DimW-1:0] HeightReset = 12'd480;
  localparam logic [9:0]      WhiteLevel  = 10'd384;
  localparam logic [7:0]      EdgeOn      = 8'd255;
  localparam logic [7:0]      EdgeOff     = 8'd0;

  // result slots of one pixel, in delivery order
  localparam int SlotAbove = 0;
  localparam int SlotLeft  = 1;
  localparam int SlotHere  = 2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0]      edge_value;
    logic [PosW-1:0] out_row;
    logic [PosW-1:0] out_col;
    logic            last_of_run;
    logic            end_of_frame;
  } result_t;

  typedef struct packed {
    logic [2:0]      mask;
    logic [2:0]      edges;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
  } job_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[rtl/bles_front.sv]
// front end: pixel accept, binarising, position counters, line store and result planning
module bles_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bles_pkg::pixel_t             in_data_i,
  input  logic                         cfg_valid_i,
  input  logic [bles_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bles_pkg::DimW-1:0]    cfg_data_i,
  output logic                         job_valid_o,
  output bles_pkg::job_t               job_o,
  input  logic                         job_ready_i
);

  typedef struct packed {
    logic has_up1;
    logic has_up2;
    logic has_left;
    logic has_left2;
    logic last_col;
    logic last_row;
  } flags_t;

  logic [bles_pkg::DimW-1:0] wd_q, ht_q, wd_eff, ht_eff;
  logic [bles_pkg::PosW-1:0] last_c, last_r;
  logic [bles_pkg::PosW-1:0] row_q, row_d, col_q, col_d;
  logic [9:0]                sum;
  logic                      cur_bit, accept, s1_adv;
  flags_t                    fl_d, s1_fl_q;
  logic                      s1_valid_q, s1_valid_d, s1_cur_q;
  logic [bles_pkg::PosW-1:0] s1_row_q, s1_col_q;

  logic [1:0]                 line_mem [bles_pkg::MaxWidth];
  logic [1:0]                 rd_a_q, wr_data;
  logic                       rd_b_q;
  logic [bles_pkg::ColAw-1:0] rd_addr_a, rd_addr_b, wr_addr;
  logic                       wr_en;

  logic pu1_q, pcur_q, ppcur_q;
  logic u1, u2, rt;

  assign wd_eff = bles_pkg::clamp_dim(wd_q, bles_pkg::DimW'(bles_pkg::MaxWidth));
  assign ht_eff = bles_pkg::clamp_dim(ht_q, bles_pkg::DimW'(bles_pkg::MaxHeight));
  assign last_c = bles_pkg::PosW'(wd_eff - bles_pkg::DimW'(1));
  assign last_r = bles_pkg::PosW'(ht_eff - bles_pkg::DimW'(1));

  assign sum     = 10'(in_data_i.red) + 10'(in_data_i.green) + 10'(in_data_i.blue);
  assign cur_bit = (sum >= bles_pkg::WhiteLevel);
  assign accept  = in_valid_i && in_ready_o;

  always_comb begin
    fl_d.has_up1   = (row_q != '0);
    fl_d.has_up2   = (row_q > bles_pkg::PosW'(1));
    fl_d.has_left  = (col_q != '0);
    fl_d.has_left2 = (col_q > bles_pkg::PosW'(1));
    fl_d.last_col  = (col_q == last_c);
    fl_d.last_row  = (row_q == last_r);
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (fl_d.last_col) begin
      col_d = '0;
      row_d = fl_d.last_row ? '0 : row_q + bles_pkg::PosW'(1);
    end else begin
      col_d = col_q + bles_pkg::PosW'(1);
    end
  end

  // line store: bit 1 two rows up, bit 0 one row up
  assign rd_addr_a = col_q[bles_pkg::ColAw-1:0];
  assign rd_addr_b = rd_addr_a + bles_pkg::ColAw'(1);
  assign wr_en     = s1_adv;
  assign wr_addr   = s1_col_q[bles_pkg::ColAw-1:0];
  assign wr_data   = {rd_a_q[0], s1_cur_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_a_q <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : line_mem[rd_addr_a];
      rd_b_q <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data[0] : line_mem[rd_addr_b][0];
    end
  end

  assign u2 = rd_a_q[1];
  assign u1 = rd_a_q[0];
  assign rt = rd_b_q;

  always_comb begin
    job_o.row = s1_row_q;
    job_o.col = s1_col_q;
    job_o.mask[bles_pkg::SlotAbove]  = s1_fl_q.has_up1;
    job_o.mask[bles_pkg::SlotLeft]   = s1_fl_q.last_row && s1_fl_q.has_left;
    job_o.mask[bles_pkg::SlotHere]   = s1_fl_q.last_row && s1_fl_q.last_col;
    job_o.edges[bles_pkg::SlotAbove] = !u1 && ((s1_fl_q.has_up2 && u2) || s1_cur_q ||
                                       (s1_fl_q.has_left && pu1_q) ||
                                       (!s1_fl_q.last_col && rt));
    job_o.edges[bles_pkg::SlotLeft]  = !pcur_q && ((s1_fl_q.has_up1 && pu1_q) ||
                                       (s1_fl_q.has_left2 && ppcur_q) || s1_cur_q);
    job_o.edges[bles_pkg::SlotHere]  = !s1_cur_q && ((s1_fl_q.has_up1 && u1) ||
                                       (s1_fl_q.has_left && pcur_q));
  end

  assign job_valid_o = s1_valid_q && (job_o.mask != '0);
  assign s1_adv      = s1_valid_q && ((job_o.mask == '0) || job_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wd_q       <= bles_pkg::WidthReset;
      ht_q       <= bles_pkg::HeightReset;
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          bles_pkg::CfgFrameWidth: begin
            wd_q  <= cfg_data_i;
            row_q <= '0;
            col_q <= '0;
          end
          bles_pkg::CfgFrameHeight: begin
            ht_q  <= cfg_data_i;
            row_q <= '0;
            col_q <= '0;
          end
          default: begin
          end
        endcase
      end else if (accept) begin
        row_q <= row_d;
        col_q <= col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cur_q <= cur_bit;
      s1_row_q <= row_q;
      s1_col_q <= col_q;
      s1_fl_q  <= fl_d;
    end
    if (s1_adv) begin
      pu1_q   <= u1;
      pcur_q  <= s1_cur_q;
      ppcur_q <= pcur_q;
    end
  end

endmodule

[rtl/bles_fifo.sv]
// short queue of planned pixel results between front and back
module bles_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  bles_pkg::job_t push_data_i,
  output logic           pop_valid_o,
  output bles_pkg::job_t pop_data_o,
  input  logic           pop_ready_i
);

  bles_pkg::job_t              entry_q [bles_pkg::QDepth];
  logic [bles_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [bles_pkg::QPtrW:0]    count_q;
  logic                        push, pop;

  assign push_ready_o = (count_q != (bles_pkg::QPtrW+1)'(bles_pkg::QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + bles_pkg::QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + bles_pkg::QPtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + (bles_pkg::QPtrW+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (bles_pkg::QPtrW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/bles_back.sv]
// back end: walks the results of each queued pixel into the output register
module bles_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  bles_pkg::job_t    head_i,
  output logic              head_pop_o,
  output logic              out_valid_o,
  output bles_pkg::result_t out_data_o,
  input  logic              out_ready_i
);

  logic [2:0]        done_q, done_d, rem, pick;
  logic              is_last, load, out_valid_q;
  bles_pkg::result_t res_d, out_q;

  assign rem = head_i.mask & ~done_q;

  always_comb begin
    pick = '0;
    priority if (rem[bles_pkg::SlotAbove]) begin
      pick[bles_pkg::SlotAbove] = 1'b1;
    end else if (rem[bles_pkg::SlotLeft]) begin
      pick[bles_pkg::SlotLeft] = 1'b1;
    end else begin
      pick[bles_pkg::SlotHere] = 1'b1;
    end
  end

  assign is_last = ((rem & ~pick) == '0);
  assign load    = head_valid_i && (!out_valid_q || out_ready_i);
  assign head_pop_o = load && is_last;

  always_comb begin
    res_d.edge_value   = ((pick & head_i.edges) != '0) ? bles_pkg::EdgeOn : bles_pkg::EdgeOff;
    res_d.out_row      = pick[bles_pkg::SlotAbove] ? head_i.row - bles_pkg::PosW'(1)
                                                   : head_i.row;
    res_d.out_col      = pick[bles_pkg::SlotLeft] ? head_i.col - bles_pkg::PosW'(1)
                                                  : head_i.col;
    res_d.last_of_run  = is_last;
    res_d.end_of_frame = pick[bles_pkg::SlotHere];
  end

  always_comb begin
    done_d = done_q;
    if (load) begin
      done_d = is_last ? '0 : (done_q | pick);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/binary_laplacian_edge_stream_top.sv]
// top level of the binary laplacian edge stream
// Takes one RGB pixel word per clock in raster order, makes it binary (white when
// red+green+blue >= 384) and gives the four-neighbour Laplacian edge value (0 or 255)
// one row late, with row and column of the filtered pixel. Outside the last row each
// pixel gives at most one result and the block sustains one pixel per clock while the
// output is taken; in the last row a pixel gives up to three results, and since the
// output register delivers one result word per clock, input is held back for those
// extra cycles. A pixel's first result goes through registered steps in order: the line
// store is read at the accepting edge, the results are planned into a four-entry queue
// and the output is loaded from its head; a full queue or a held output stalls the later
// steps. The line store is a 2048 x 2 bit memory with one write and two read ports; it
// needs no clearing after reset. Frame width and height (12 bit, 0 acts as 1, above 2048
// acts as 2048) are to be written through the configuration channel while the block is
// idle, not enforced by the block; each write restarts the frame at pixel (0, 0).
module binary_laplacian_edge_stream_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bles_pkg::pixel_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bles_pkg::result_t            out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bles_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bles_pkg::DimW-1:0]    cfg_data_i
);

  logic           job_valid, job_ready, head_valid, head_pop;
  bles_pkg::job_t job, head;

  assign cfg_ready_o = 1'b1;

  bles_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  bles_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  (job),
    .pop_valid_o  (head_valid),
    .pop_data_o   (head),
    .pop_ready_i  (head_pop)
  );

  bles_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .out_ready_i  (out_ready_i)
  );

  // frame end closes the run of its pixel
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_frame |-> out_data_o.last_of_run)
    else $error("end of frame word not last of run");

  // only black or white comes out
  a_edge_binary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.edge_value == bles_pkg::EdgeOn) ||
                    (out_data_o.edge_value == bles_pkg::EdgeOff))
    else $error("edge value not binary");

  // a popped queue entry always carries at least one result
  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid |-> (head.mask != '0))
    else $error("queued pixel without results");

endmodule
